// ===== rtl/core/kste_pkg.sv =====
package kste_pkg;

  // Field widths fixed by the register map and the result format.
  localparam int STEP_W   = 31;
  localparam int LEN_W    = 16;
  localparam int VOL_W    = 15;
  localparam int MAG_W    = 15;
  localparam int SAMPLE_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [MAG_W-1:0] FULL_SCALE = 15'd32767;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_LENGTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_LENGTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FALL_LENGTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME       = 3'd5;

  localparam logic [VOL_W-1:0] VOLUME_RST = 15'd16384;
  localparam logic [LEN_W-1:0] LENGTH_RST = 16'd1;

  // Depth of the job queue between front and back.
  localparam int JOB_Q_DEPTH = 2;

  // Control flags of one job.
  typedef struct packed {
    logic idle;   // tick outside a tone: all-zero result
    logic last;   // last sample of the tone
    logic ramp;   // envelope scaling num/den applies
  } job_ctl_t;

  // Quarter-wave entry k of a 2^tbits table, sin(pi/2 * k / 2^tbits) * 32767.
  // Used only with constant arguments (table built at elaboration).
  function automatic logic [MAG_W-1:0] sine_entry(input int unsigned k,
                                                   input int unsigned tbits);
    longint unsigned a;
    longint unsigned a2;
    longint unsigned term;
    longint          sum;
    longint          v;
    a    = (64'(k) * 64'd1686629713) >> tbits;
    a2   = (a * a) >> 30;
    term = a;
    sum  = longint'(a);
    term = ((term * a2) >> 30) / 64'd6;   sum = sum - longint'(term);
    term = ((term * a2) >> 30) / 64'd20;  sum = sum + longint'(term);
    term = ((term * a2) >> 30) / 64'd42;  sum = sum - longint'(term);
    term = ((term * a2) >> 30) / 64'd72;  sum = sum + longint'(term);
    term = ((term * a2) >> 30) / 64'd110; sum = sum - longint'(term);
    term = ((term * a2) >> 30) / 64'd156; sum = sum + longint'(term);
    if (sum <= 0) begin
      v = 0;
    end else begin
      v = longint'(((unsigned'(sum)) * 64'd32767 + 64'd536870912) >> 30);
      if (v > 32767) begin
        v = 32767;
      end
    end
    return MAG_W'(v);
  endfunction

endpackage

// ===== rtl/core/kste_queue.sv =====
module kste_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/kste_front.sv =====
module kste_front #(
  parameter int PHASE_BITS      = 32,
  parameter int TABLE_ADDR_BITS = 10,
  parameter int LENGTH_BITS     = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           take,
  input  logic                           begin_req,
  input  logic                           use_long,
  input  logic [kste_pkg::STEP_W-1:0]    phase_step,
  input  logic [kste_pkg::LEN_W-1:0]     short_length,
  input  logic [kste_pkg::LEN_W-1:0]     long_length,
  input  logic [kste_pkg::LEN_W-1:0]     rise_length,
  input  logic [kste_pkg::LEN_W-1:0]     fall_length,
  output kste_pkg::job_ctl_t             job_ctl,
  output logic [TABLE_ADDR_BITS+1:0]     job_phase,
  output logic [LENGTH_BITS-1:0]         job_num,
  output logic [kste_pkg::LEN_W-1:0]     job_den
);
  import kste_pkg::*;

  // compare width covering both the index and the 16-bit ramp lengths
  localparam int CW = ((LENGTH_BITS > LEN_W) ? LENGTH_BITS : LEN_W) + 1;

  logic [LENGTH_BITS-1:0] sample_index;
  logic [PHASE_BITS-1:0]  phase_acc;
  logic [LENGTH_BITS-1:0] tone_length;
  logic                   playing;

  logic [LEN_W-1:0]       len_sel;
  logic [LENGTH_BITS-1:0] cur_len;
  logic [LENGTH_BITS-1:0] cur_idx;
  logic [PHASE_BITS-1:0]  cur_phase;
  logic                   cur_play;
  logic                   rise_hit;
  logic                   fall_hit;
  logic                   last_hit;

  always_comb begin
    len_sel = use_long ? long_length : short_length;
    if (begin_req) begin
      cur_len   = LENGTH_BITS'(len_sel);
      cur_idx   = '0;
      cur_phase = '0;
      cur_play  = (LENGTH_BITS'(len_sel) != '0);
    end else begin
      cur_len   = tone_length;
      cur_idx   = sample_index;
      cur_phase = phase_acc;
      cur_play  = playing;
    end

    rise_hit = CW'(cur_idx) < CW'(rise_length);
    fall_hit = (fall_length != '0) &&
               ((CW'(cur_idx) + CW'(fall_length)) > CW'(cur_len));
    last_hit = ((CW'(cur_idx) + CW'(1)) >= CW'(cur_len));

    job_ctl.idle = !cur_play;
    job_ctl.last = cur_play && last_hit;
    job_ctl.ramp = cur_play && (rise_hit || fall_hit);
    job_phase    = cur_play ? cur_phase[PHASE_BITS-1 -: TABLE_ADDR_BITS+2] : '0;
    // attack wins over release
    job_num      = rise_hit ? cur_idx : (cur_len - cur_idx);
    job_den      = rise_hit ? rise_length : fall_length;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
      phase_acc    <= '0;
      tone_length  <= '0;
      playing      <= 1'b0;
    end else if (take) begin
      tone_length <= cur_len;
      if (cur_play) begin
        sample_index <= cur_idx + 1'b1;
        phase_acc    <= cur_phase + PHASE_BITS'(phase_step);
        playing      <= !last_hit;
      end else begin
        sample_index <= cur_idx;
        phase_acc    <= cur_phase;
        playing      <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/kste_back.sv =====
module kste_back #(
  parameter int TABLE_ADDR_BITS = 10,
  parameter int LENGTH_BITS     = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              job_empty,
  input  kste_pkg::job_ctl_t                job_ctl,
  input  logic [TABLE_ADDR_BITS+1:0]        job_phase,
  input  logic [LENGTH_BITS-1:0]            job_num,
  input  logic [kste_pkg::LEN_W-1:0]        job_den,
  input  logic [kste_pkg::VOL_W-1:0]        volume,
  input  logic                              pop,
  output logic                              job_pop,
  output logic signed [kste_pkg::SAMPLE_W-1:0] sample,
  output logic                              active,
  output logic                              final_res,
  output logic                              empty
);
  import kste_pkg::*;

  localparam int TBL    = 1 << TABLE_ADDR_BITS;
  localparam int PROD_W = VOL_W + MAG_W;
  localparam int RMP_W  = MAG_W + LENGTH_BITS;
  localparam int CNT_W  = $clog2(MAG_W);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_SCL  = 6'b000100,
    ST_RMP  = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t state;

  // quarter-wave table, built at elaboration, registered read
  logic [MAG_W-1:0] rom [TBL];
  for (genvar k = 0; k < TBL; k++) begin : g_rom
    assign rom[k] = sine_entry(k, TABLE_ADDR_BITS);
  end

  logic [TABLE_ADDR_BITS-1:0] j;
  logic [1:0]                 quad;
  logic [TABLE_ADDR_BITS-1:0] rom_addr;
  logic [MAG_W-1:0]           rom_q;

  job_ctl_t               ctl;
  logic                   neg;
  logic                   full_mag;
  logic [LENGTH_BITS-1:0] num;
  logic [LEN_W-1:0]       den;
  logic [PROD_W-1:0]      prod;
  logic [MAG_W-1:0]       mag;
  logic [LEN_W-1:0]       rem;
  logic [MAG_W-1:0]       quo;
  logic [CNT_W-1:0]       cnt;
  logic                   out_full;

  logic [MAG_W-1:0]       s_mag;
  logic [MAG_W-1:0]       q1;
  logic [MAG_W:0]         r1;
  logic [MAG_W:0]         base;
  logic [RMP_W-1:0]       rmp;
  logic [LEN_W:0]         trial;
  logic                   ge;
  logic [MAG_W-1:0]       mag_out;
  logic                   done_wr;

  assign j        = job_phase[TABLE_ADDR_BITS-1:0];
  assign quad     = job_phase[TABLE_ADDR_BITS+1:TABLE_ADDR_BITS];
  // odd quadrants mirror the table
  assign rom_addr = quad[0] ? (~j + 1'b1) : j;

  always_ff @(posedge clk) begin
    rom_q <= rom[rom_addr];
  end

  always_comb begin
    s_mag = full_mag ? FULL_SCALE : rom_q;
    // divide by 2^15-1: estimate x>>15, remainder below 2^16, two corrections
    q1    = prod[PROD_W-1:MAG_W];
    r1    = {1'b0, prod[MAG_W-1:0]} + {1'b0, q1};
    base  = {1'b0, q1} + (MAG_W+1)'(r1 >= {1'b0, FULL_SCALE})
                       + (MAG_W+1)'(r1 >= {FULL_SCALE, 1'b0});
    rmp   = RMP_W'(mag) * RMP_W'(num);
    trial = {rem, quo[MAG_W-1]};
    ge    = trial >= {1'b0, den};
    mag_out = ctl.ramp ? quo : mag;
  end

  assign job_pop = (state == ST_IDLE) && !job_empty;
  assign done_wr = (state == ST_DONE) && (!out_full || pop);
  assign empty   = !out_full;

  always_ff @(posedge clk) begin
    if (job_pop) begin
      ctl      <= job_ctl;
      neg      <= quad[1];
      full_mag <= quad[0] && (j == '0);
      num      <= job_num;
      den      <= job_den;
    end
    case (state)
      ST_IDLE: begin
        mag <= '0;
      end
      ST_MUL: begin
        prod <= PROD_W'(volume) * PROD_W'(s_mag);
      end
      ST_SCL: begin
        mag <= base[MAG_W-1:0];
      end
      ST_RMP: begin
        // quotient fits MAG_W bits since num < den: high part starts below den
        rem <= LEN_W'(rmp >> MAG_W);
        quo <= rmp[MAG_W-1:0];
      end
      ST_DIV: begin
        rem <= ge ? LEN_W'(trial - {1'b0, den}) : trial[LEN_W-1:0];
        quo <= {quo[MAG_W-2:0], ge};
      end
      default: begin
      end
    endcase
    if (done_wr) begin
      sample    <= neg ? -$signed({1'b0, mag_out}) : $signed({1'b0, mag_out});
      active    <= !ctl.idle;
      final_res <= ctl.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      out_full <= 1'b0;
    end else begin
      if (done_wr) begin
        out_full <= 1'b1;
      end else if (pop && out_full) begin
        out_full <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!job_empty) begin
            state <= job_ctl.idle ? ST_DONE : ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_SCL;
        end
        ST_SCL: begin
          state <= ctl.ramp ? ST_RMP : ST_DONE;
        end
        ST_RMP: begin
          cnt   <= CNT_W'(MAG_W - 1);
          state <= ST_DIV;
        end
        ST_DIV: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_full || pop) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/keyed_sine_tone_envelope.sv =====
// Keyed sine tone generator with linear attack and release: every beat pushed
// in is one audio tick and yields exactly one result beat (sample, active,
// final_res), in order. A tick with begin_req starts a short or long tone and
// restarts the phase; idle ticks give zero. The front end takes one beat per
// clock while its two-entry job queue has room (full rises otherwise), so
// ticks can be pushed while an earlier result still waits to be popped. The
// back end works one job at a time: a sample passes the multiply, scale and
// result states, an idle tick just the result state; inside a ramp a 15-step
// restoring divider (one quotient bit per clock) comes before the result state.
// There is no clearing pass after reset. Registers are written through the
// cfg port, which is always ready; write them only while no tick is in
// flight.
module keyed_sine_tone_envelope #(
  parameter int PHASE_BITS      = 32,
  parameter int TABLE_ADDR_BITS = 10,
  parameter int LENGTH_BITS     = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // tick input queue side
  input  logic                                  push,
  output logic                                  full,
  input  logic                                  begin_req,
  input  logic                                  use_long,
  // result queue side
  input  logic                                  pop,
  output logic                                  empty,
  output logic signed [kste_pkg::SAMPLE_W-1:0]  sample,
  output logic                                  active,
  output logic                                  final_res,
  // register write channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [kste_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [kste_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import kste_pkg::*;

  localparam int PH_TOP_W = TABLE_ADDR_BITS + 2;
  localparam int JOB_W    = $bits(job_ctl_t) + PH_TOP_W + LENGTH_BITS + LEN_W;

  // configuration registers
  logic [STEP_W-1:0] phase_step;
  logic [LEN_W-1:0]  short_length;
  logic [LEN_W-1:0]  long_length;
  logic [LEN_W-1:0]  rise_length;
  logic [LEN_W-1:0]  fall_length;
  logic [VOL_W-1:0]  volume;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step   <= '0;
      short_length <= LENGTH_RST;
      long_length  <= LENGTH_RST;
      rise_length  <= LENGTH_RST;
      fall_length  <= LENGTH_RST;
      volume       <= VOLUME_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PHASE_STEP:   phase_step   <= cfg_data[STEP_W-1:0];
        REG_SHORT_LENGTH: short_length <= cfg_data[LEN_W-1:0];
        REG_LONG_LENGTH:  long_length  <= cfg_data[LEN_W-1:0];
        REG_RISE_LENGTH:  rise_length  <= cfg_data[LEN_W-1:0];
        REG_FALL_LENGTH:  fall_length  <= cfg_data[LEN_W-1:0];
        REG_VOLUME:       volume       <= cfg_data[VOL_W-1:0];
        default: begin
          // unmapped index: write dropped
        end
      endcase
    end
  end

  // front: tone sequencing, classifies each tick into a job
  logic                   take;
  job_ctl_t               f_ctl;
  logic [PH_TOP_W-1:0]    f_phase;
  logic [LENGTH_BITS-1:0] f_num;
  logic [LEN_W-1:0]       f_den;

  assign take = push && !full;

  kste_front #(
    .PHASE_BITS      (PHASE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .LENGTH_BITS     (LENGTH_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .begin_req    (begin_req),
    .use_long     (use_long),
    .phase_step   (phase_step),
    .short_length (short_length),
    .long_length  (long_length),
    .rise_length  (rise_length),
    .fall_length  (fall_length),
    .job_ctl      (f_ctl),
    .job_phase    (f_phase),
    .job_num      (f_num),
    .job_den      (f_den)
  );

  // job queue decouples the per-tick front from the multi-cycle back
  logic [JOB_W-1:0]       q_wr;
  logic [JOB_W-1:0]       q_rd;
  logic                   q_empty;
  logic                   q_pop;
  job_ctl_t               b_ctl;
  logic [PH_TOP_W-1:0]    b_phase;
  logic [LENGTH_BITS-1:0] b_num;
  logic [LEN_W-1:0]       b_den;

  assign q_wr = {f_ctl, f_phase, f_num, f_den};
  assign {b_ctl, b_phase, b_num, b_den} = q_rd;

  kste_queue #(
    .WIDTH (JOB_W),
    .DEPTH (JOB_Q_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (take),
    .wr_data (q_wr),
    .rd_en   (q_pop),
    .rd_data (q_rd),
    .full    (full),
    .empty   (q_empty)
  );

  // back: table lookup, volume scale, envelope divide, result register
  kste_back #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .LENGTH_BITS     (LENGTH_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_empty (q_empty),
    .job_ctl   (b_ctl),
    .job_phase (b_phase),
    .job_num   (b_num),
    .job_den   (b_den),
    .volume    (volume),
    .pop       (pop),
    .job_pop   (q_pop),
    .sample    (sample),
    .active    (active),
    .final_res (final_res),
    .empty     (empty)
  );

endmodule
